>>> rtl/tetb_pkg.sv
// ----------------------------------------------------------------------------
// tetb_pkg: shared types and constants for the trace buffer
// Field widths, request codes and the compare result carried to the top.
// ----------------------------------------------------------------------------
package tetb_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int TYPE_W  = 2;
    localparam int STAMP_W = 64;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_RANGE = 2'd1,
        REQ_KIND  = 2'd2
    } t_req_type;

    // Compare unit outcome for one stored entry
    typedef struct packed {
        logic in_range;
        logic kind_eq;
    } t_hit;

endpackage

>>> rtl/tetb_req_if.sv
// ----------------------------------------------------------------------------
// tetb_req_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface tetb_req_if import tetb_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [TYPE_W-1:0]  req_type;
    logic [STAMP_W-1:0] stamp;
    logic [KIND_W-1:0]  event_kind;
    logic [STAMP_W-1:0] range_low;
    logic [STAMP_W-1:0] range_high;
    logic [CNT_W-1:0]   max_matches;

    modport source (
        output valid, req_type, stamp, event_kind, range_low, range_high, max_matches,
        input  ready
    );

    modport sink (
        input  valid, req_type, stamp, event_kind, range_low, range_high, max_matches,
        output ready
    );

endinterface

>>> rtl/tetb_rsp_if.sv
// ----------------------------------------------------------------------------
// tetb_rsp_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tetb_rsp_if import tetb_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   match_index;
    logic               match_valid;
    logic               last_result;
    logic [CNT_W-1:0]   kind_count;
    logic [CNT_W-1:0]   entry_count;
    logic [STAMP_W-1:0] span;

    modport source (
        output valid, match_index, match_valid, last_result, kind_count, entry_count,
               span,
        input  ready
    );

    modport sink (
        input  valid, match_index, match_valid, last_result, kind_count, entry_count,
               span,
        output ready
    );

endinterface

>>> rtl/timestamped_event_trace_buffer.sv
// ----------------------------------------------------------------------------
// timestamped_event_trace_buffer: circular trace log, drop oldest
// Holds up to DEPTH timestamped events; answers range and kind queries by
// scanning the log oldest to newest through one compare unit.
// ----------------------------------------------------------------------------
//
//  Port     Dir  Handshake     Item
//  -------  ---  ------------  -----------------------------------------------
//  i_req    in   valid/ready   request: add, range query or kind query
//  o_rsp    out  valid/ready   result: match position, counts, stamp span
//
//  Add: writes the entry; when full, it also re-reads the new oldest stamp.
//  Queries: each held entry is read from the RAM, then compared, one entry
//  at a time, since the single RAM read port serves the whole scan.
//  o_rsp stalls hold range scans and the last item; i_req.ready only in S_IDLE.
//  Reset empties the log at once; the RAM needs no clearing pass.
//
module timestamped_event_trace_buffer import tetb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tetb_req_if.sink     i_req,
    tetb_rsp_if.source   o_rsp
);

    localparam int SW    = $clog2(DEPTH);       // slot / position index
    localparam int CW    = $clog2(DEPTH + 1);   // fill and match counts
    localparam int RAM_W = KIND_W + STAMP_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_WRITE    = 7'b0000010,
        S_OLD_RD   = 7'b0000100,
        S_OLD_CAP  = 7'b0001000,
        S_SCAN_RD  = 7'b0010000,
        S_SCAN_CHK = 7'b0100000,
        S_RESULT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]   match_index;
        logic               match_valid;
        logic               last_result;
        logic [CNT_W-1:0]   kind_count;
        logic [CNT_W-1:0]   entry_count;
        logic [STAMP_W-1:0] span;
    } t_rsp;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(DEPTH - 1)) ? '0 : s + SW'(1);
    endfunction

    // control state
    t_state        r_state,      n_state;
    logic [SW-1:0] r_oldest,     n_oldest;
    logic [SW-1:0] r_tail,       n_tail;      // next write slot
    logic [CW-1:0] r_fill,       n_fill;
    logic [SW-1:0] r_slot,       n_slot;      // RAM read address
    logic [CW-1:0] r_pos,        n_pos;
    logic [CW-1:0] r_nmatch,     n_nmatch;
    logic [CW-1:0] r_kcnt,       n_kcnt;
    logic          r_pend_valid, n_pend_valid; // one match held back for last flag
    logic          r_out_valid;

    // payload
    logic [STAMP_W-1:0] r_first,    n_first;   // oldest stamp held
    logic [STAMP_W-1:0] r_last,     n_last;    // newest stamp held
    logic [SW-1:0]      r_pend_idx, n_pend_idx;
    t_req_type          r_type;
    logic [STAMP_W-1:0] r_stamp;
    logic [KIND_W-1:0]  r_kind;
    logic [STAMP_W-1:0] r_low;
    logic [STAMP_W-1:0] r_high;
    logic [CNT_W-1:0]   r_cap;
    t_rsp               r_out;

    logic             req_fire;
    logic             out_free;
    logic             ld;
    logic             ld_valid;
    logic [SW-1:0]    ld_idx;
    logic             ld_last;
    logic             ram_we;
    logic [RAM_W-1:0] ram_rdata;
    t_hit             hit;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign ram_we      = (r_state == S_WRITE);

    // One RAM holds kind and stamp of every slot
    tetb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({r_kind, r_stamp}),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    tetb_match u_match (
        .i_stamp    (ram_rdata[STAMP_W-1:0]),
        .i_kind     (ram_rdata[RAM_W-1:STAMP_W]),
        .i_low      (r_low),
        .i_high     (r_high),
        .i_kind_req (r_kind),
        .o_hit      (hit)
    );

    // Sequencer
    always_comb begin
        logic done;
        logic last_pos;
        logic cap_hit;

        n_state      = r_state;
        n_oldest     = r_oldest;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_slot       = r_slot;
        n_pos        = r_pos;
        n_nmatch     = r_nmatch;
        n_kcnt       = r_kcnt;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_first      = r_first;
        n_last       = r_last;
        ld           = 1'b0;
        ld_valid     = 1'b0;
        ld_idx       = '0;
        ld_last      = 1'b0;
        done         = 1'b0;
        last_pos     = ((r_pos + CW'(1)) == r_fill);
        cap_hit      = ((CNT_W'(r_nmatch) + CNT_W'(1)) == r_cap);

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_pos        = '0;
                    n_slot       = r_oldest;
                    n_nmatch     = '0;
                    n_kcnt       = '0;
                    n_pend_valid = 1'b0;
                    case (t_req_type'(i_req.req_type))
                        REQ_ADD: begin
                            n_state = S_WRITE;
                        end
                        REQ_RANGE: begin
                            n_state = (r_fill == '0 || i_req.max_matches == '0) ?
                                      S_RESULT : S_SCAN_RD;
                        end
                        REQ_KIND: begin
                            n_state = (r_fill == '0) ? S_RESULT : S_SCAN_RD;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                n_last = r_stamp;
                if (r_fill == '0) begin
                    n_first = r_stamp;
                end
                n_tail = slot_inc(r_tail);
                if (r_fill == CW'(DEPTH)) begin
                    // full: overwrite oldest, then fetch the new oldest stamp
                    n_oldest = slot_inc(r_oldest);
                    n_slot   = slot_inc(r_oldest);
                    n_state  = S_OLD_RD;
                end else begin
                    n_fill  = r_fill + CW'(1);
                    n_state = S_RESULT;
                end
            end
            S_OLD_RD: begin
                n_state = S_OLD_CAP;
            end
            S_OLD_CAP: begin
                n_first = ram_rdata[STAMP_W-1:0];
                n_state = S_RESULT;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_type == REQ_KIND) begin
                    if (hit.kind_eq) begin
                        n_kcnt = r_kcnt + CW'(1);
                    end
                    done = last_pos;
                    if (done) begin
                        n_state = S_RESULT;
                    end else begin
                        n_pos   = r_pos + CW'(1);
                        n_slot  = slot_inc(r_slot);
                        n_state = S_SCAN_RD;
                    end
                end else if (hit.in_range && r_pend_valid && !out_free) begin
                    // previous match still waiting for the output register
                    n_state = S_SCAN_CHK;
                end else begin
                    if (hit.in_range) begin
                        if (r_pend_valid) begin
                            ld       = 1'b1;
                            ld_valid = 1'b1;
                            ld_idx   = r_pend_idx;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_pos[SW-1:0];
                        n_nmatch     = r_nmatch + CW'(1);
                        done         = last_pos || cap_hit;
                    end else begin
                        done = last_pos;
                    end
                    if (done) begin
                        n_state = S_RESULT;
                    end else begin
                        n_pos   = r_pos + CW'(1);
                        n_slot  = slot_inc(r_slot);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_RESULT: begin
                // final item: held-back match if any, else a status item
                if (out_free) begin
                    ld       = 1'b1;
                    ld_valid = r_pend_valid;
                    ld_idx   = r_pend_valid ? r_pend_idx : '0;
                    ld_last  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_oldest     <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_slot       <= '0;
            r_pos        <= '0;
            r_nmatch     <= '0;
            r_kcnt       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_oldest     <= n_oldest;
            r_tail       <= n_tail;
            r_fill       <= n_fill;
            r_slot       <= n_slot;
            r_pos        <= n_pos;
            r_nmatch     <= n_nmatch;
            r_kcnt       <= n_kcnt;
            r_pend_valid <= n_pend_valid;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first    <= n_first;
        r_last     <= n_last;
        r_pend_idx <= n_pend_idx;
        if (req_fire) begin
            r_type  <= t_req_type'(i_req.req_type);
            r_stamp <= i_req.stamp;
            r_kind  <= i_req.event_kind;
            r_low   <= i_req.range_low;
            r_high  <= i_req.range_high;
            r_cap   <= i_req.max_matches;
        end
        if (ld) begin
            r_out.match_index <= IDX_W'(ld_idx);
            r_out.match_valid <= ld_valid;
            r_out.last_result <= ld_last;
            r_out.kind_count  <= (r_type == REQ_KIND) ? CNT_W'(r_kcnt) : '0;
            r_out.entry_count <= CNT_W'(r_fill);
            // span is zero below two entries
            r_out.span        <= (r_fill >= CW'(2)) ? (r_last - r_first) : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.match_index = r_out.match_index;
    assign o_rsp.match_valid = r_out.match_valid;
    assign o_rsp.last_result = r_out.last_result;
    assign o_rsp.kind_count  = r_out.kind_count;
    assign o_rsp.entry_count = r_out.entry_count;
    assign o_rsp.span        = r_out.span;

endmodule

>>> rtl/tetb_ram.sv
// ----------------------------------------------------------------------------
// tetb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tetb_ram import tetb_pkg::*; #(
    parameter int WIDTH = STAMP_W + KIND_W,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tetb_match.sv
// ----------------------------------------------------------------------------
// tetb_match: shared entry compare unit
// Bounds check of one stamp and kind equality for the scan sequencer.
// ----------------------------------------------------------------------------
module tetb_match import tetb_pkg::*; (
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [STAMP_W-1:0] i_low,
    input  logic [STAMP_W-1:0] i_high,
    input  logic [KIND_W-1:0]  i_kind_req,
    output t_hit               o_hit
);

    always_comb begin
        o_hit.in_range = (i_stamp >= i_low) && (i_stamp <= i_high);
        o_hit.kind_eq  = (i_kind == i_kind_req);
    end

endmodule
